@@ hw/rtl/sha224_block_hasher_assert.svh @@
// Assertion macros for the SHA-224 block hasher checker.
// Needs clk_i in the scope of every use, and rst_ni as well for SHA224_ASSERT.
`ifndef SHA224_BLOCK_HASHER_ASSERT_SVH
`define SHA224_BLOCK_HASHER_ASSERT_SVH

// Property sampled on the rising clock edge, switched off while reset is applied.
`define SHA224_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Property that must hold at every edge, reset included.
`define SHA224_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`endif

@@ hw/rtl/sha224_pkg.sv @@
// Shared types, constants and round functions of the SHA-224 block hasher.
// No dependencies; compiled before every other file of the block.
package sha224_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned StateWords = 8;

  typedef logic [WordW-1:0] word_t;
  typedef logic [3:0]       word_cnt_t;
  typedef logic [5:0]       round_cnt_t;
  typedef logic [2:0]       digest_idx_t;

  localparam round_cnt_t  LastRound        = 6'd63;
  // From this round on, the word prepared for the following round is expanded.
  localparam round_cnt_t  FirstExpandRound = 6'd15;
  localparam digest_idx_t LastDigestIdx    = 3'd6;

  localparam word_t InitHash [StateWords] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    word_t message_word;
    logic  first_of_message;
    logic  last_of_message;
  } in_req_t;

  typedef struct packed {
    word_t       digest_word;
    digest_idx_t digest_index;
    logic        last_digest_word;
  } out_req_t;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StRound,
    StFinal,
    StOut
  } state_e;

  typedef struct packed {
    logic push;
    logic step;
    logic expand;
  } sched_ctrl_t;

  typedef struct packed {
    logic init_hash;
    logic load_work;
    logic do_round;
    logic add_hash;
  } round_ctrl_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(word_t e, word_t f, word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(word_t a, word_t b, word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ hw/rtl/sha224_stream_if.sv @@
// Valid/ready stream channel used for the message and digest ports.
// The request type is set by the instantiating scope (see sha224_pkg).
interface sha224_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

@@ hw/rtl/sha224_sched.sv @@
// Message schedule of the SHA-224 block hasher: a sixteen-word shift line.
// Depends on sha224_pkg.
module sha224_sched (
  input  logic                     clk_i,
  input  sha224_pkg::sched_ctrl_t  ctrl_i,
  input  sha224_pkg::word_t        word_i,
  output sha224_pkg::word_t        wt_o
);
  import sha224_pkg::*;

  // Entry 0 is the oldest word; words enter at the top.
  word_t win_q [BlockWords];
  word_t win_d [BlockWords];
  word_t wt_q;
  word_t wt_d;
  word_t w_new;

  always_comb begin
    if (ctrl_i.expand) begin
      w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    end else begin
      w_new = win_q[0];
    end
  end

  always_comb begin
    win_d = win_q;
    wt_d  = wt_q;
    if (ctrl_i.push || ctrl_i.step) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[BlockWords-1] = ctrl_i.push ? word_i : w_new;
    end
    if (ctrl_i.step) begin
      wt_d = w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    wt_q  <= wt_d;
  end

  assign wt_o = wt_q;

endmodule

@@ hw/rtl/sha224_round.sv @@
// Round unit and chaining state of the SHA-224 block hasher.
// Depends on sha224_pkg.
module sha224_round (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sha224_pkg::round_ctrl_t  ctrl_i,
  input  sha224_pkg::word_t        wt_i,
  input  sha224_pkg::word_t        k_i,
  output sha224_pkg::word_t        hash_o [sha224_pkg::StateWords]
);
  import sha224_pkg::*;

  word_t hash_q [StateWords];
  word_t hash_d [StateWords];
  word_t work_q [StateWords];
  word_t work_d [StateWords];
  word_t t1;
  word_t t2;

  // Working variables a..h sit at entries 0..7.
  assign t1 = work_q[7] + big_sigma1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6])
            + k_i + wt_i;
  assign t2 = big_sigma0(work_q[0]) + majority(work_q[0], work_q[1], work_q[2]);

  always_comb begin
    hash_d = hash_q;
    work_d = work_q;
    if (ctrl_i.init_hash) begin
      hash_d = InitHash;
    end else if (ctrl_i.add_hash) begin
      for (int i = 0; i < StateWords; i++) begin
        hash_d[i] = hash_q[i] + work_q[i];
      end
    end
    if (ctrl_i.load_work) begin
      work_d = hash_q;
    end else if (ctrl_i.do_round) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= InitHash;
    end else begin
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign hash_o = hash_q;

endmodule

@@ hw/rtl/sha224_block_hasher.sv @@
// SHA-224 block hasher top level: sequencer, schedule line and one shared round unit.
// Depends on sha224_pkg, sha224_stream_if, sha224_sched and sha224_round.
// Sequence: after the request that completes a block come preparation, the rounds and the
// final add, then the digest words if the block ended its message. Throughput: the round
// unit does one of the 64 rounds per cycle; message words are taken only while idle.
// Reset: asynchronous, active low; chaining state returns to the initial hash.
module sha224_block_hasher (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  sha224_stream_if.sink           msg_i,
  sha224_stream_if.source         dig_o
);
  import sha224_pkg::*;

  // Sequencer state. The block takes message requests only while idle; once the
  // sixteenth word of a block arrives it walks through a preparation state, the 64
  // rounds and a final state that adds the round result into the chaining
  // state. If the block ended its message, the seven digest words follow.
  state_e      state_q, state_d;
  word_cnt_t   cnt_q, cnt_d;
  round_cnt_t  rnd_q, rnd_d;
  digest_idx_t idx_q, idx_d;
  logic        last_q, last_d;

  logic        in_acc;
  logic        out_acc;
  logic        block_done;
  word_cnt_t   cnt_next;

  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;
  word_t       wt;
  word_t       k_word;
  word_t       hash [StateWords];

  // Ready is high only while idle and valid only while sending the digest, so the
  // handshakes are formed from the state directly rather than from the port values.
  assign in_acc  = msg_i.valid && (state_q == StIdle);
  assign out_acc = dig_o.ready && (state_q == StOut);

  // A first-of-message word restarts the block count, dropping any partial block.
  assign cnt_next   = (msg_i.payload.first_of_message ? '0 : cnt_q) + 4'd1;
  assign block_done = in_acc && (cnt_next == '0);

  assign k_word = RoundK[rnd_q];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (block_done) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        state_d = StRound;
      end
      StRound: begin
        if (rnd_q == LastRound) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        state_d = last_q ? StOut : StIdle;
      end
      StOut: begin
        if (out_acc && (idx_q == LastDigestIdx)) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Outputs of the sequencer and counter updates.
  always_comb begin
    msg_i.ready = 1'b0;
    dig_o.valid = 1'b0;
    sched_ctrl  = '0;
    round_ctrl  = '0;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    last_d      = last_q;

    sched_ctrl.push      = in_acc;
    round_ctrl.init_hash = in_acc && msg_i.payload.first_of_message;

    case (state_q)
      StIdle: begin
        msg_i.ready = 1'b1;
        if (in_acc) begin
          cnt_d  = cnt_next;
          last_d = msg_i.payload.last_of_message;
        end
      end
      StPrep: begin
        // Loads the working variables and brings the word for round 0 forward.
        sched_ctrl.step      = 1'b1;
        round_ctrl.load_work = 1'b1;
        rnd_d                = '0;
      end
      StRound: begin
        // The schedule line prepares the word of the following round.
        sched_ctrl.step     = 1'b1;
        sched_ctrl.expand   = (rnd_q >= FirstExpandRound);
        round_ctrl.do_round = 1'b1;
        rnd_d               = rnd_q + 6'd1;
      end
      StFinal: begin
        round_ctrl.add_hash = 1'b1;
        idx_d               = '0;
      end
      StOut: begin
        dig_o.valid = 1'b1;
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
        end
      end
      default: begin
        msg_i.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    dig_o.payload.digest_word      = hash[idx_q];
    dig_o.payload.digest_index     = idx_q;
    dig_o.payload.last_digest_word = (idx_q == LastDigestIdx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  sha224_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_i (msg_i.payload.message_word),
    .wt_o   (wt)
  );

  sha224_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (round_ctrl),
    .wt_i   (wt),
    .k_i    (k_word),
    .hash_o (hash)
  );

endmodule

@@ hw/rtl/sha224_checker.sv @@
// Port-level checks of the SHA-224 block hasher and the bind that attaches them.
// Depends on sha224_pkg and sha224_block_hasher_assert.svh.
`include "sha224_block_hasher_assert.svh"

module sha224_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input sha224_pkg::out_req_t out_req_i
);
  import sha224_pkg::*;

  logic        out_acc;
  logic        out_last;
  digest_idx_t out_idx;
  digest_idx_t out_inc;

  assign out_acc  = out_valid_i && out_ready_i;
  assign out_last = out_req_i.last_digest_word;
  assign out_idx  = out_req_i.digest_index;
  assign out_inc  = out_idx + 3'd1;

  // The block never takes message words while digest words are pending.
  `SHA224_ASSERT_ALWAYS(a_no_overlap, !(in_ready_i && out_valid_i))

  // Digest words come out in order, one index after the other.
  `SHA224_ASSERT(a_idx_step, out_acc && !out_last |=> out_valid_i && out_idx == $past(out_inc))

  // Only the seventh word carries the last mark.
  `SHA224_ASSERT(a_last_mark, out_valid_i |-> (out_last == (out_idx == LastDigestIdx)))

  // A stalled digest request holds.
  `SHA224_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_req_i))

  // After the last digest word the block is idle and takes words again.
  `SHA224_ASSERT(a_back_idle, out_acc && out_last |=> !out_valid_i && in_ready_i)

endmodule

bind sha224_block_hasher sha224_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (msg_i.ready),
  .out_valid_i (dig_o.valid),
  .out_ready_i (dig_o.ready),
  .out_req_i   (dig_o.payload)
);

@@ bench/sha224_block_hasher_test.sv @@
// Self-checking bench for the SHA-224 block hasher: drives message words and checks
// every digest word against a predictor of its own. Depends on sha224_pkg, sha224_stream_if
// and the block itself.
module sha224_block_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sha224_pkg::*;

  // Bound on the run length, far above what a correct run needs, so only a hang reaches it.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomWords  = 410;
  // Idling stops once fewer than this many requests are still waiting to be sent.
  localparam int unsigned CalmTail     = 48;
  // Quiet cycles after the last digest word, long enough for one more compression.
  localparam int unsigned DrainCycles  = 100;
  localparam int unsigned ReportLimit  = 10;

  // Round constants and initial hash of the standard, held here independently of the design.
  localparam logic [0:63][31:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] StartHash = {
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  logic clk;
  logic rst_n;

  sha224_stream_if #(.payload_t(in_req_t))  msg_if ();
  sha224_stream_if #(.payload_t(out_req_t)) dig_if ();

  sha224_block_hasher dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  // Requests waiting to be sent, filled once before reset is released.
  in_req_t     message_words[$];
  // Digest words that the accepted requests have made due, oldest first.
  out_req_t    digest_due[$];

  // Predictor state: chaining hash, the words of the block being collected, and their count.
  word_t       chain[8];
  word_t       window[16];
  logic [3:0]  fill;

  int unsigned words_accepted = 0;
  int unsigned total_words;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  in_req_t     held_word;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic word_t rot_right(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Runs the 64 rounds over the collected block, expanding the schedule in place in the
  // sixteen-word window, and adds the working variables into the chaining hash.
  task automatic sha224_compress();
    word_t a, b, c, d, e, f, g, h;
    word_t w, w15, w2, t1, t2;
    int    t;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = window[t];
      end else begin
        w15 = window[(t - 15) & 15];
        w2  = window[(t - 2) & 15];
        w = window[t & 15]
            + (rot_right(w15, 7) ^ rot_right(w15, 18) ^ (w15 >> 3))
            + window[(t - 7) & 15]
            + (rot_right(w2, 17) ^ rot_right(w2, 19) ^ (w2 >> 10));
        window[t & 15] = w;
      end
      t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
             + ((e & f) ^ (~e & g)) + RoundConst[t] + w;
      t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  // Takes one accepted request into the predictor. A first flag reloads the initial hash and
  // throws away any partial block; a last flag only counts when its word closes a block.
  task automatic sha224_absorb(in_req_t req);
    out_req_t due;
    int       k;
    if (req.first_of_message) begin
      for (k = 0; k < 8; k++) chain[k] = StartHash[k];
      fill = '0;
    end
    window[fill] = req.message_word;
    fill = fill + 4'd1;
    if (fill == 4'd0) begin
      sha224_compress();
      if (req.last_of_message) begin
        for (k = 0; k < 7; k++) begin
          due.digest_word      = chain[k];
          due.digest_index     = digest_idx_t'(k);
          due.last_digest_word = (k == 6);
          digest_due.push_back(due);
        end
      end
    end
  endtask

  task automatic report_fault(string what);
    if (fault_count < ReportLimit) $display("%0t: %s", $realtime, what);
    fault_count++;
  endtask

  task automatic queue_word(word_t word, logic first, logic last);
    in_req_t req;
    req.message_word     = word;
    req.first_of_message = first;
    req.last_of_message  = last;
    message_words.push_back(req);
  endtask

  // Mostly random content, with a fair share of the all-zero, all-one and one-hot patterns.
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Request driver. A new request is offered only once the previous one has gone, and
  // valid is assigned once per edge so it never drops between back-to-back requests.
  // During reset it also puts the predictor back to the reset state of the block.
  always @(posedge clk) begin : request_driver
    logic take;
    logic offer;
    int   k;
    if (!rst_n) begin
      msg_if.valid   <= 1'b0;
      msg_if.payload <= '0;
      fill = '0;
      for (k = 0; k < 8; k++) chain[k] = StartHash[k];
      for (k = 0; k < 16; k++) window[k] = '0;
    end else begin
      take = msg_if.valid && msg_if.ready;
      if (take) begin
        sha224_absorb(held_word);
        words_accepted++;
      end
      if (take || !msg_if.valid) begin
        offer = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (message_words.size() != 0) begin
          if (message_words.size() >= CalmTail && $urandom_range(0, 5) == 0) begin
            // This cycle opens an idle burst, and send_gap counts the idle cycles that follow it.
            send_gap = $urandom_range(0, 4);
          end else begin
            held_word = message_words.pop_front();
            msg_if.payload <= held_word;
            offer = 1'b1;
          end
        end
        msg_if.valid <= offer;
      end
    end
  end

  // Digest monitor: checks every accepted digest word against the oldest one due, and
  // stalls the block in random bursts until the stimulus is nearly spent.
  always @(posedge clk) begin : digest_monitor
    out_req_t seen;
    out_req_t want;
    logic     next_ready;
    if (!rst_n) begin
      dig_if.ready <= 1'b0;
    end else begin
      if (dig_if.valid && dig_if.ready) begin
        seen = dig_if.payload;
        if (digest_due.size() == 0) begin
          report_fault($sformatf("unexpected digest word %h index %0d last %b",
                                 seen.digest_word, seen.digest_index, seen.last_digest_word));
        end else begin
          want = digest_due.pop_front();
          if (seen.digest_word !== want.digest_word ||
              seen.digest_index !== want.digest_index ||
              seen.last_digest_word !== want.last_digest_word) begin
            report_fault($sformatf(
              "digest mismatch: expected %h index %0d last %b, got %h index %0d last %b",
              want.digest_word, want.digest_index, want.last_digest_word,
              seen.digest_word, seen.digest_index, seen.last_digest_word));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (message_words.size() >= CalmTail && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      dig_if.ready <= next_ready;
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned blocks;
    int unsigned span;
    int unsigned kind;
    logic        stray;

    rst_n = 1'b0;

    // Directed part. The first block comes with no first flag, so it must hash from the
    // reset state; its words swing between all zeros and all ones, and a last flag on word
    // six, which does not close the block, must be ignored.
    for (i = 0; i < 16; i++) begin
      queue_word((i % 2) ? 32'hffffffff : 32'h00000000, 1'b0, (i == 6) || (i == 15));
    end
    // Words after a digest without a fresh first flag keep chaining from the current hash.
    queue_word(32'h61626380, 1'b0, 1'b0);
    queue_word(32'h80000000, 1'b0, 1'b0);
    queue_word(32'h00000001, 1'b0, 1'b0);
    // A first flag in the middle of a block drops the partial block and starts over; the
    // last flag on that same word is ignored as it closes no block.
    queue_word(32'h7fffffff, 1'b1, 1'b1);
    queue_word(32'hfffffffe, 1'b0, 1'b0);
    queue_word(32'h00000018, 1'b0, 1'b0);

    // Random part: mostly well-formed messages of one to three blocks with random content,
    // some chained on without a first flag, and some bursts of loose words with random flags.
    while (message_words.size() < 22 + RandomWords) begin
      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
        blocks = $urandom_range(1, 3);
        stray  = ($urandom_range(0, 3) == 0);
        for (i = 0; i < blocks * 16; i++) begin
          queue_word(pick_word(),
                     (i == 0) && (kind != 7),
                     (i == blocks * 16 - 1) || (stray && $urandom_range(0, 7) == 0));
        end
      end else begin
        span = $urandom_range(1, 15);
        for (i = 0; i < span; i++) begin
          queue_word(pick_word(), $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
        end
      end
    end
    total_words = message_words.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted != total_words) @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);
    // Any digest word that turns up now was never due.
    repeat (DrainCycles) @(posedge clk);

    if (fault_count == 0 && digest_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
